// ----- rtl/core/vmtb_pkg.sv -----
// Shared types and constants for the vertex morph-target blend unit.
// Used by vmtb_lane and vertex_morph_target_blend_unit; depends on nothing.
package vmtb_pkg;

  localparam int unsigned MAX_TARGETS = 6;
  localparam int unsigned NUM_WEIGHTS = 6;
  localparam int unsigned COORD_W     = 32;
  localparam int unsigned PROD_W      = 64;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned TERM_W      = PROD_W - FRAC_BITS;
  localparam int unsigned ACC_W       = 52;
  localparam int unsigned SUM_W       = ACC_W + 1;
  localparam int unsigned INT_W       = SUM_W - FRAC_BITS;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  typedef enum logic [1:0] {
    FMT_UBYTE = 2'b00,
    FMT_SHORT = 2'b01,
    FMT_FIXED = 2'b10
  } elem_fmt_t;

  typedef enum logic {
    KIND_BASE   = 1'b0,
    KIND_TARGET = 1'b1
  } item_kind_t;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_FORMAT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_BASE   = 3'd2;

  typedef struct packed {
    logic s1_load;
    logic s1_is_base;
    logic base_load;
    logic s2_load;
    logic s2_start;
    logic acc_upd;
    logic s3_load;
    logic s4_load;
    logic out_load;
  } lane_ctl_t;

endpackage

// ----- rtl/core/vertex_morph_target_blend_unit.sv -----
// Vertex morph-target blend unit: top level with handshake, configuration
// registers, vertex sequencing and three coordinate lanes.
// Depends on vmtb_pkg and vmtb_lane.
//
// Usage: send one base request (item_kind 0) per vertex followed by
// target_count target requests (item_kind 1). After the last target, one
// result carries base + sum(weight_t * (target_t - base)) in output_format.
// A target request with no open vertex is dropped; a base request restarts
// the vertex. With target_count 0 the base request alone yields a result.
// Input channel: in_valid/in_stall; result channel: out_valid/out_stall;
// configuration: cfg_we/cfg_index/cfg_data, written while idle.
// Path: a result's last request passes the input, product, accumulate, sum
// and output registers before the result appears on out_valid.
// Throughput: one request per cycle while in_stall is low; the per-target
// multiply and the accumulator update each take one pipeline stage.
// Reset clears configuration to zero, closes any vertex and empties the pipe.
// When the receiver stalls, the result holds and the stages behind it keep
// filling; in_stall rises only once the input stage cannot move forward.
module vertex_morph_target_blend_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_item_kind,
  input  logic [1:0]                          in_element_format,
  input  logic signed [31:0]                  in_coord_x,
  input  logic signed [31:0]                  in_coord_y,
  input  logic signed [31:0]                  in_coord_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [31:0]                  out_x,
  output logic signed [31:0]                  out_y,
  output logic signed [31:0]                  out_z,
  input  logic                                cfg_we,
  input  logic [vmtb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vmtb_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import vmtb_pkg::*;

  logic [2:0]        target_count_r;
  logic [1:0]        output_format_r;
  logic signed [31:0] weight_r [NUM_WEIGHTS];

  logic       s1_valid_r;
  logic       s1_kind_r;
  logic       s2_valid_r;
  logic       s2_start_r;
  logic       s2_emit_r;
  logic       s3_valid_r;
  logic       s4_valid_r;
  logic       out_valid_r;
  logic       open_r;
  logic [2:0] seen_r;

  logic       out_ready;
  logic       s4_ready;
  logic       s4_leave;
  logic       s3_ready;
  logic       s3_leave;
  logic       s2_ready;
  logic       s2_leave;
  logic       s1_leave;
  logic       accept;
  logic       is_base;
  logic       pass;
  logic       emit;
  logic [2:0] eff_count;
  logic [2:0] seen_inc;
  logic [2:0] weight_idx;
  logic signed [31:0] weight_sel;
  lane_ctl_t  ctl;

  assign out_ready = !out_valid_r || !out_stall;
  assign s4_ready  = !s4_valid_r || out_ready;
  assign s4_leave  = s4_valid_r && out_ready;
  assign s3_ready  = !s3_valid_r || s4_ready;
  assign s3_leave  = s3_valid_r && s4_ready;
  assign s2_ready  = !s2_valid_r || !s2_emit_r || s3_ready;
  assign s2_leave  = s2_valid_r && (!s2_emit_r || s3_ready);
  assign s1_leave  = s1_valid_r && s2_ready;
  assign in_stall  = s1_valid_r && !s2_ready;
  assign accept    = in_valid && !in_stall;

  assign eff_count = (target_count_r > 3'(MAX_TARGETS)) ? 3'(MAX_TARGETS) : target_count_r;
  assign seen_inc  = seen_r + 3'd1;
  assign is_base   = (s1_kind_r == KIND_BASE);
  assign pass      = is_base || open_r;
  assign emit      = is_base ? (eff_count == 3'd0) : (seen_inc >= eff_count);

  assign weight_idx = (seen_r >= 3'(NUM_WEIGHTS)) ? (seen_r - 3'(NUM_WEIGHTS)) : seen_r;
  assign weight_sel = weight_r[weight_idx];

  always_comb begin
    ctl.s1_load    = accept;
    ctl.s1_is_base = is_base;
    ctl.base_load  = s1_leave && is_base;
    ctl.s2_load    = s1_leave && pass;
    ctl.s2_start   = s2_start_r;
    ctl.acc_upd    = s2_leave;
    ctl.s3_load    = s2_leave && s2_emit_r;
    ctl.s4_load    = s3_leave;
    ctl.out_load   = s4_leave;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_count_r  <= '0;
      output_format_r <= '0;
      for (int i = 0; i < NUM_WEIGHTS; i++) begin
        weight_r[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TARGET_COUNT:  target_count_r  <= cfg_data[2:0];
        CFG_OUTPUT_FORMAT: output_format_r <= cfg_data[1:0];
        default:           weight_r[cfg_index - CFG_WEIGHT_BASE] <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      open_r      <= 1'b0;
      seen_r      <= '0;
    end else begin
      s1_valid_r  <= accept || (s1_valid_r && !s1_leave);
      s2_valid_r  <= (s1_leave && pass) || (s2_valid_r && !s2_leave);
      s3_valid_r  <= (s2_leave && s2_emit_r) || (s3_valid_r && !s3_leave);
      s4_valid_r  <= s3_leave || (s4_valid_r && !s4_leave);
      out_valid_r <= s4_leave || (out_valid_r && out_stall);
      if (s1_leave) begin
        if (is_base) begin
          open_r <= !emit;
          seen_r <= '0;
        end else if (open_r) begin
          open_r <= !emit;
          seen_r <= seen_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind_r <= in_item_kind;
    end
    if (s1_leave) begin
      s2_start_r <= is_base;
      s2_emit_r  <= emit;
    end
  end

  vmtb_lane u_lane_x (
    .clk     (clk),
    .ctl     (ctl),
    .in_fmt  (in_element_format),
    .coord   (in_coord_x),
    .weight  (weight_sel),
    .out_fmt (output_format_r),
    .result  (out_x)
  );

  vmtb_lane u_lane_y (
    .clk     (clk),
    .ctl     (ctl),
    .in_fmt  (in_element_format),
    .coord   (in_coord_y),
    .weight  (weight_sel),
    .out_fmt (output_format_r),
    .result  (out_y)
  );

  vmtb_lane u_lane_z (
    .clk     (clk),
    .ctl     (ctl),
    .in_fmt  (in_element_format),
    .coord   (in_coord_z),
    .weight  (weight_sel),
    .out_fmt (output_format_r),
    .result  (out_z)
  );

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/core/vmtb_lane.sv -----
// Datapath for one coordinate of the blend pipeline: widen, weighted
// difference, accumulate, final sum and output conversion.
// Depends on vmtb_pkg; stage enables come from the top level.
module vmtb_lane (
  input  logic                     clk,
  input  vmtb_pkg::lane_ctl_t      ctl,
  input  logic [1:0]               in_fmt,
  input  logic signed [31:0]       coord,
  input  logic signed [31:0]       weight,
  input  logic [1:0]               out_fmt,
  output logic signed [31:0]       result
);
  import vmtb_pkg::*;

  logic signed [COORD_W-1:0] wide;
  logic signed [COORD_W-1:0] s1_coord_r;
  logic signed [COORD_W-1:0] base_r;
  logic signed [COORD_W:0]   diff;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  s2_prod_r;
  logic signed [COORD_W-1:0] s2_base_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [ACC_W-1:0]   acc_nxt;
  logic signed [ACC_W-1:0]   s3_acc_r;
  logic signed [COORD_W-1:0] s3_base_r;
  logic signed [SUM_W-1:0]   sum;
  logic signed [SUM_W-1:0]   s4_sum_r;
  logic signed [INT_W-1:0]   int_floor;
  logic signed [INT_W-1:0]   int_trunc;
  logic signed [31:0]        result_nxt;
  logic signed [31:0]        result_r;

  always_comb begin
    unique case (in_fmt)
      FMT_UBYTE: wide = {8'd0, coord[7:0], 16'd0};
      FMT_SHORT: wide = {coord[15:0], 16'd0};
      default:   wide = coord;
    endcase
  end

  assign diff = {s1_coord_r[COORD_W-1], s1_coord_r} - {base_r[COORD_W-1], base_r};
  assign prod = diff * weight;

  always_comb begin
    if (ctl.s2_start) begin
      acc_nxt = '0;
    end else begin
      acc_nxt = acc_r
              + {{(ACC_W-TERM_W){s2_prod_r[PROD_W-1]}}, s2_prod_r[PROD_W-1:FRAC_BITS]}
              + {{(ACC_W-1){1'b0}}, s2_prod_r[FRAC_BITS-1]};
    end
  end

  assign sum = {{(SUM_W-COORD_W){s3_base_r[COORD_W-1]}}, s3_base_r}
             + {s3_acc_r[ACC_W-1], s3_acc_r};

  assign int_floor = s4_sum_r[SUM_W-1:FRAC_BITS];
  assign int_trunc = int_floor
                   + {{(INT_W-1){1'b0}},
                      (s4_sum_r[SUM_W-1] && (s4_sum_r[FRAC_BITS-1:0] != '0))};

  always_comb begin
    unique case (out_fmt)
      FMT_UBYTE: begin
        if (int_trunc[INT_W-1]) begin
          result_nxt = 32'sd0;
        end else if (int_trunc > 37'sd255) begin
          result_nxt = 32'sd255;
        end else begin
          result_nxt = int_trunc[31:0];
        end
      end
      FMT_SHORT: begin
        if (int_trunc < -37'sd32768) begin
          result_nxt = -32'sd32768;
        end else if (int_trunc > 37'sd32767) begin
          result_nxt = 32'sd32767;
        end else begin
          result_nxt = int_trunc[31:0];
        end
      end
      default: begin
        if (s4_sum_r < -53'sd2147483648) begin
          result_nxt = 32'h8000_0000;
        end else if (s4_sum_r > 53'sd2147483647) begin
          result_nxt = 32'h7FFF_FFFF;
        end else begin
          result_nxt = s4_sum_r[31:0];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.s1_load) begin
      s1_coord_r <= wide;
    end
    if (ctl.base_load) begin
      base_r <= s1_coord_r;
    end
    if (ctl.s2_load) begin
      s2_prod_r <= prod;
      s2_base_r <= ctl.s1_is_base ? s1_coord_r : base_r;
    end
    if (ctl.acc_upd) begin
      acc_r <= acc_nxt;
    end
    if (ctl.s3_load) begin
      s3_acc_r  <= acc_nxt;
      s3_base_r <= s2_base_r;
    end
    if (ctl.s4_load) begin
      s4_sum_r <= sum;
    end
    if (ctl.out_load) begin
      result_r <= result_nxt;
    end
  end

  assign result = result_r;

endmodule

// ----- tb/vertex_morph_target_blend_unit_tb.sv -----
// Self-checking testbench for vertex_morph_target_blend_unit: directed table, then random
// vertex streams under random and long stalls, checked against an in-bench blend predictor.
// Depends on vmtb_pkg and the RTL of the blend unit.
module vertex_morph_target_blend_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vmtb_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned NUM_PHASES    = 16;
  localparam int unsigned PHASE_ITEMS   = 100;
  localparam int unsigned HOLD_PHASE    = 4;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned MAX_PRINTS    = 100;
  localparam logic [1:0]  FMT_UNUSED    = 2'd3;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } vtx_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_act_t;

  typedef struct packed {
    row_act_t              act;
    logic                  kind;
    logic [1:0]            fmt;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [31:0]           x;
    logic [31:0]           y;
    logic [31:0]           z;
    bit                    typed;
    vtx_t                  want;
  } row_t;

  localparam int unsigned DIR_ROWS = 30;

  row_t dir_rows [DIR_ROWS] = '{
    '{ROW_ITEM, KIND_BASE, FMT_UBYTE, 3'd0, 32'hFFFF_FFFF, 32'h0, 32'h1234_5680,
      1'b1, '{32'd255, 32'd0, 32'd128}},
    '{ROW_ITEM, KIND_BASE, FMT_SHORT, 3'd0, 32'h0000_7FFF, 32'hFFFF_8000, 32'h0001_0005,
      1'b1, '{32'd255, 32'd0, 32'd5}},
    '{ROW_ITEM, KIND_TARGET, FMT_UBYTE, 3'd0, 32'h11, 32'h22, 32'h33, 1'b0, '0},
    '{ROW_CFG, KIND_BASE, FMT_UBYTE, CFG_OUTPUT_FORMAT, 32'(FMT_SHORT), 32'h0, 32'h0,
      1'b0, '0},
    '{ROW_ITEM, KIND_BASE, FMT_FIXED, 3'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0001,
      1'b1, '{32'd32767, 32'hFFFF_8000, 32'd0}},
    '{ROW_ITEM, KIND_BASE, FMT_UNUSED, 3'd0, 32'h0005_8000, 32'hFFFA_8000, 32'h0,
      1'b1, '{32'd5, 32'hFFFF_FFFB, 32'd0}},
    '{ROW_CFG, KIND_BASE, FMT_UBYTE, CFG_OUTPUT_FORMAT, 32'(FMT_FIXED), 32'h0, 32'h0,
      1'b0, '0},
    '{ROW_CFG, KIND_BASE, FMT_UBYTE, CFG_WEIGHT_BASE, 32'h0001_0000, 32'h0, 32'h0,
      1'b0, '0},
    '{ROW_CFG, KIND_BASE, FMT_UBYTE, CFG_WEIGHT_BASE + 3'd1, 32'h7FFF_FFFF, 32'h0, 32'h0,
      1'b0, '0},
    '{ROW_CFG, KIND_BASE, FMT_UBYTE, CFG_WEIGHT_BASE + 3'd2, 32'h8000_0000, 32'h0, 32'h0,
      1'b0, '0},
    '{ROW_CFG, KIND_BASE, FMT_UBYTE, CFG_WEIGHT_BASE + 3'd3, 32'hFFFF_8000, 32'h0, 32'h0,
      1'b0, '0},
    '{ROW_CFG, KIND_BASE, FMT_UBYTE, CFG_WEIGHT_BASE + 3'd4, 32'h0000_8000, 32'h0, 32'h0,
      1'b0, '0},
    '{ROW_CFG, KIND_BASE, FMT_UBYTE, CFG_WEIGHT_BASE + 3'd5, 32'h0000_0001, 32'h0, 32'h0,
      1'b0, '0},
    '{ROW_CFG, KIND_BASE, FMT_UBYTE, CFG_TARGET_COUNT, 32'd7, 32'h0, 32'h0, 1'b0, '0},
    '{ROW_ITEM, KIND_BASE, FMT_FIXED, 3'd0, 32'h0001_0000, 32'hFFFF_0000, 32'h0, 1'b0, '0},
    '{ROW_ITEM, KIND_TARGET, FMT_UBYTE, 3'd0, 32'hFF, 32'h0, 32'h80, 1'b0, '0},
    '{ROW_ITEM, KIND_TARGET, FMT_SHORT, 3'd0, 32'h8000, 32'h7FFF, 32'hFFFF, 1'b0, '0},
    '{ROW_ITEM, KIND_TARGET, FMT_FIXED, 3'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1,
      1'b0, '0},
    '{ROW_ITEM, KIND_TARGET, FMT_UNUSED, 3'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
      1'b0, '0},
    '{ROW_ITEM, KIND_TARGET, FMT_FIXED, 3'd0, 32'h0001_8000, 32'hFFFE_8000, 32'h0000_8000,
      1'b0, '0},
    '{ROW_ITEM, KIND_TARGET, FMT_FIXED, 3'd0, 32'hFFFF_FFFF, 32'h1, 32'h7FFF_FFFF, 1'b0, '0},
    '{ROW_CFG, KIND_BASE, FMT_UBYTE, CFG_OUTPUT_FORMAT, 32'(FMT_UNUSED), 32'h0, 32'h0,
      1'b0, '0},
    '{ROW_CFG, KIND_BASE, FMT_UBYTE, CFG_TARGET_COUNT, 32'd3, 32'h0, 32'h0, 1'b0, '0},
    '{ROW_ITEM, KIND_BASE, FMT_SHORT, 3'd0, 32'h1, 32'h2, 32'h3, 1'b0, '0},
    '{ROW_ITEM, KIND_BASE, FMT_FIXED, 3'd0, 32'h0002_0000, 32'hFFFD_0000, 32'h0000_4000,
      1'b0, '0},
    '{ROW_ITEM, KIND_TARGET, FMT_UBYTE, 3'd0, 32'h4, 32'h5, 32'h6, 1'b0, '0},
    '{ROW_ITEM, KIND_TARGET, FMT_SHORT, 3'd0, 32'hFFFF, 32'hFFFE, 32'h10, 1'b0, '0},
    '{ROW_CFG, KIND_BASE, FMT_UBYTE, CFG_TARGET_COUNT, 32'd1, 32'h0, 32'h0, 1'b0, '0},
    '{ROW_ITEM, KIND_TARGET, FMT_FIXED, 3'd0, 32'h0003_0000, 32'h0, 32'hFFFF_C000, 1'b0, '0},
    '{ROW_ITEM, KIND_TARGET, FMT_UBYTE, 3'd0, 32'h7, 32'h8, 32'h9, 1'b0, '0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_item_kind = 1'b0;
  logic [1:0]            in_element_format = 2'd0;
  logic signed [31:0]    in_coord_x = '0;
  logic signed [31:0]    in_coord_y = '0;
  logic signed [31:0]    in_coord_z = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic signed [31:0]    out_x;
  logic signed [31:0]    out_y;
  logic signed [31:0]    out_z;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [2:0]   cfg_targets = '0;
  logic [1:0]   cfg_out_fmt = '0;
  logic [31:0]  cfg_weight [NUM_WEIGHTS] = '{default: '0};
  longint       base_fx [3] = '{default: 0};
  longint       delta_acc [3] = '{default: 0};
  logic [2:0]   targets_taken = '0;
  bit           vtx_open = 1'b0;

  vtx_t         blended_q [$];
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  hold_req = 0;
  bit           idle_en = 1'b1;
  bit           stall_en = 1'b1;

  vertex_morph_target_blend_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_item_kind      (in_item_kind),
    .in_element_format (in_element_format),
    .in_coord_x        (in_coord_x),
    .in_coord_y        (in_coord_y),
    .in_coord_z        (in_coord_z),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_x             (out_x),
    .out_y             (out_y),
    .out_z             (out_z),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint widen_coord(logic [1:0] fmt, logic [31:0] c);
    case (fmt)
      FMT_UBYTE: return longint'(c[7:0]) * 65536;
      FMT_SHORT: return longint'($signed(c[15:0])) * 65536;
      default:   return longint'($signed(c));
    endcase
  endfunction

  function automatic longint sat(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic [31:0] to_out_format(longint v);
    longint t;
    t = (v >= 0) ? (v >>> FRAC_BITS) : -((-v) >>> FRAC_BITS);
    case (cfg_out_fmt)
      FMT_UBYTE: t = sat(t, 0, 255);
      FMT_SHORT: t = sat(t, -32768, 32767);
      default:   t = sat(v, -64'sd2147483648, 64'sd2147483647);
    endcase
    return t[31:0];
  endfunction

  function automatic void morph_blend_step(input logic kind, input logic [1:0] fmt,
                                           input vtx_t coords, output bit emitted,
                                           output vtx_t blended);
    logic [31:0] c [3];
    longint      w;
    longint      prod;
    int unsigned eff;
    c[0] = coords.x;
    c[1] = coords.y;
    c[2] = coords.z;
    emitted = 1'b0;
    blended = '0;
    eff = (cfg_targets > MAX_TARGETS) ? MAX_TARGETS : cfg_targets;
    if (kind == KIND_BASE) begin
      for (int i = 0; i < 3; i++) begin
        base_fx[i] = widen_coord(fmt, c[i]);
        delta_acc[i] = 0;
      end
      targets_taken = '0;
      vtx_open = 1'b1;
      emitted = (eff == 0);
    end else if (vtx_open) begin
      w = longint'($signed(cfg_weight[targets_taken % NUM_WEIGHTS]));
      for (int i = 0; i < 3; i++) begin
        prod = w * (widen_coord(fmt, c[i]) - base_fx[i]);
        delta_acc[i] += (prod + 64'sd32768) >>> FRAC_BITS;
      end
      targets_taken = targets_taken + 3'd1;
      emitted = (targets_taken >= eff);
    end
    if (emitted) begin
      vtx_open = 1'b0;
      blended.x = to_out_format(base_fx[0] + delta_acc[0]);
      blended.y = to_out_format(base_fx[1] + delta_acc[1]);
      blended.z = to_out_format(base_fx[2] + delta_acc[2]);
    end
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatch_count < MAX_PRINTS)
      $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (idx == CFG_TARGET_COUNT) begin
      cfg_targets = data[2:0];
    end else if (idx == CFG_OUTPUT_FORMAT) begin
      cfg_out_fmt = data[1:0];
    end else begin
      cfg_weight[idx - CFG_WEIGHT_BASE] = data;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (blended_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_request(input logic kind, input logic [1:0] fmt, input vtx_t coords,
                              input bit use_typed, input vtx_t typed_v, output bit ignored);
    int unsigned gap;
    bit          emitted;
    vtx_t        blended;
    gap = idle_en ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item_kind <= kind;
    in_element_format <= fmt;
    in_coord_x <= coords.x;
    in_coord_y <= coords.y;
    in_coord_z <= coords.z;
    do @(posedge clk); while (in_stall);
    ignored = (kind == KIND_TARGET) && !vtx_open;
    morph_blend_step(kind, fmt, coords, emitted, blended);
    if (emitted)
      blended_q.push_back(use_typed ? typed_v : blended);
  endtask

  function automatic logic [31:0] pick_coord(logic [1:0] fmt);
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: begin
        if (fmt == FMT_FIXED || fmt == FMT_UNUSED)
          return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
        return $urandom();
      end
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_weight();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return $urandom();
      default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    endcase
  endfunction

  task automatic send_vertex(output int unsigned taken);
    int unsigned eff;
    int unsigned n;
    int unsigned r;
    logic [1:0]  f;
    vtx_t        c;
    bit          ign;
    taken = 0;
    eff = (cfg_targets > MAX_TARGETS) ? MAX_TARGETS : cfg_targets;
    r = $urandom_range(0, 9);
    if (r != 8) begin
      f = 2'($urandom_range(0, 3));
      c = '{pick_coord(f), pick_coord(f), pick_coord(f)};
      send_request(KIND_BASE, f, c, 1'b0, '0, ign);
      taken++;
    end
    n = (r == 8) ? 1 : ((r == 9) ? $urandom_range(0, eff) : eff);
    repeat (n) begin
      f = 2'($urandom_range(0, 3));
      c = '{pick_coord(f), pick_coord(f), pick_coord(f)};
      send_request(KIND_TARGET, f, c, 1'b0, '0, ign);
      if (!ign) taken++;
    end
  endtask

  always @(posedge clk) begin : result_check
    vtx_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (blended_q.size() == 0) begin
        report_mismatch("unexpected result, out_x", out_x, '0);
      end else begin
        want = blended_q.pop_front();
        if (out_x !== want.x) report_mismatch("out_x", out_x, want.x);
        if (out_y !== want.y) report_mismatch("out_y", out_y, want.y);
        if (out_z !== want.z) report_mismatch("out_z", out_z, want.z);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** vertex_morph_target_blend_unit: FAILED **");
      $finish;
    end
  end

  initial begin : receiver
    int unsigned pause;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req != 0) begin
        pause = hold_req;
        hold_req = 0;
      end else begin
        pause = stall_en ? $urandom_range(0, 8) : 0;
      end
      if (pause != 0) begin
        out_stall <= 1'b1;
        repeat (pause) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    int unsigned accepted;
    int unsigned taken;
    logic [31:0] cnt_v;
    logic [31:0] fmt_v;
    logic [31:0] wt;
    bit          ign;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].act == ROW_CFG) begin
        drain();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].x);
        cfg_we <= 1'b0;
      end else begin
        send_request(dir_rows[i].kind, dir_rows[i].fmt,
                     '{dir_rows[i].x, dir_rows[i].y, dir_rows[i].z},
                     dir_rows[i].typed, dir_rows[i].want, ign);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      case (ph)
        0: begin cnt_v = 6; fmt_v = 32'(FMT_FIXED); end
        1: begin cnt_v = 0; fmt_v = 32'(FMT_UBYTE); end
        2: begin cnt_v = 7; fmt_v = 32'(FMT_UNUSED); end
        HOLD_PHASE: begin cnt_v = $urandom_range(0, 1); fmt_v = $urandom_range(0, 3); end
        default: begin cnt_v = $urandom_range(0, 7); fmt_v = $urandom_range(0, 3); end
      endcase
      write_reg(CFG_TARGET_COUNT, cnt_v);
      write_reg(CFG_OUTPUT_FORMAT, fmt_v);
      for (int k = 0; k < NUM_WEIGHTS; k++) begin
        wt = (ph == 0) ? 32'h7FFF_FFFF : (ph == 1) ? 32'h8000_0000 :
             (ph == 2) ? 32'h0 : pick_weight();
        write_reg(CFG_IDX_W'(CFG_WEIGHT_BASE + k), wt);
      end
      cfg_we <= 1'b0;
      idle_en = (ph != HOLD_PHASE) && ($urandom_range(0, 3) != 0);
      stall_en = ($urandom_range(0, 3) != 0);
      if (ph == HOLD_PHASE) hold_req = HOLD_CYCLES;
      accepted = 0;
      while (accepted < PHASE_ITEMS) begin
        send_vertex(taken);
        accepted += taken;
      end
    end

    drain();
    if (mismatch_count == 0) begin
      $display("** vertex_morph_target_blend_unit: PASSED **");
    end else begin
      $display("** vertex_morph_target_blend_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/vmtb_pkg.sv
rtl/core/vmtb_lane.sv
rtl/core/vertex_morph_target_blend_unit.sv
tb/vertex_morph_target_blend_unit_tb.sv
